/* rtl/core/bpcc_pkg.sv */
// ----------------------------------------------------------------------------
// bpcc_pkg
// Shared types, codes and decode helpers for the commit-time branch
// predictor check (gshare counters, tagged BTB, return address stack).
// ----------------------------------------------------------------------------
package bpcc_pkg;

    localparam int ADDR_W = 32;
    localparam int HIST_W = 16;
    localparam int HB_W   = 5;

    // major opcodes and quadrant codes
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [1:0] QUAD_FULL = 2'h3;
    localparam logic [1:0] QUAD_C1   = 2'h1;
    localparam logic [1:0] QUAD_C2   = 2'h2;

    // compressed funct3 codes
    localparam logic [2:0] C_F3_JAL  = 3'd1;
    localparam logic [2:0] C_F3_J    = 3'd5;
    localparam logic [2:0] C_F3_BEQZ = 3'd6;
    localparam logic [2:0] C_F3_BNEZ = 3'd7;
    localparam logic [2:0] C_F3_JR   = 3'd4;

    // branch funct3 codes that are not defined, and the jalr funct3
    localparam logic [2:0] F3_RSV0 = 3'd2;
    localparam logic [2:0] F3_RSV1 = 3'd3;
    localparam logic [2:0] F3_JALR = 3'd0;

    // link registers and the zero register
    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_T0 = 5'd5;
    localparam logic [4:0] REG_ZERO = 5'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_EVAL
    } bpcc_state_t;

    typedef struct packed {
        logic ctrl;
        logic cond;
        logic push;
        logic pop;
    } bpcc_dec_t;

    function automatic logic is_link(input logic [4:0] r);
        return (r == REG_RA) || (r == REG_T0);
    endfunction

    // returns {pop, push}
    function automatic logic [1:0] jalr_act(input logic [4:0] rd, input logic [4:0] rs1);
        logic dl;
        logic sl;
        dl = is_link(rd);
        sl = is_link(rs1);
        return {sl && !(dl && (rd == rs1)), dl};
    endfunction

    function automatic bpcc_dec_t bpcc_decode(input logic [31:0] w);
        bpcc_dec_t d;
        logic [2:0] cf3;
        logic [2:0] f3;
        logic [4:0] crd;
        logic [4:0] crs2;
        logic [4:0] rs1;
        logic [6:0] op;
        d    = '0;
        cf3  = w[15:13];
        f3   = w[14:12];
        crd  = w[11:7];
        crs2 = w[6:2];
        rs1  = w[19:15];
        op   = w[6:0];
        if (w[1:0] != QUAD_FULL)
        begin
            if (w[1:0] == QUAD_C1)
            begin
                if (cf3 == C_F3_JAL)
                begin
                    d.ctrl = 1'b1;
                    d.push = 1'b1;
                end
                else if (cf3 == C_F3_J)
                begin
                    d.ctrl = 1'b1;
                end
                else if (cf3 == C_F3_BEQZ || cf3 == C_F3_BNEZ)
                begin
                    d.ctrl = 1'b1;
                    d.cond = 1'b1;
                end
            end
            else if (w[1:0] == QUAD_C2 && cf3 == C_F3_JR && crs2 == REG_ZERO
                     && crd != REG_ZERO)
            begin
                d.ctrl = 1'b1;
                if (!w[12])
                    d.pop = is_link(crd);
                else
                    {d.pop, d.push} = jalr_act(REG_RA, crd);
            end
        end
        else
        begin
            if (op == OP_BRANCH)
            begin
                if (f3 != F3_RSV0 && f3 != F3_RSV1)
                begin
                    d.ctrl = 1'b1;
                    d.cond = 1'b1;
                end
            end
            else if (op == OP_JAL)
            begin
                d.ctrl = 1'b1;
                d.push = is_link(crd);
            end
            else if (op == OP_JALR && f3 == F3_JALR)
            begin
                d.ctrl = 1'b1;
                {d.pop, d.push} = jalr_act(crd, rs1);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/core/bpcc_ram.sv */
// ----------------------------------------------------------------------------
// bpcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bpcc_mod.sv */
// ----------------------------------------------------------------------------
// bpcc_mod
// Remainder of a 32-bit value by a fixed table size: a mask for powers of
// two, otherwise a reciprocal multiply, a multiply-subtract and one
// correcting subtract.
// ----------------------------------------------------------------------------
module bpcc_mod #(
    parameter int MOD = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [31:0]                          value,
    output logic                                 done,
    output logic [(MOD > 1 ? $clog2(MOD) : 1)-1:0] rem
);

    localparam int  IW   = (MOD > 1) ? $clog2(MOD) : 1;
    localparam int  RW   = $clog2(MOD + 1);
    localparam bit  POW2 = ((MOD & (MOD - 1)) == 0);
    localparam logic [31:0] MODV  = 32'(MOD);
    // floor(2^32 / MOD): the quotient estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MOD));

    logic [31:0]   val_reg;
    logic [31:0]   quo_reg;
    logic [31:0]   diff_reg;
    logic [RW-1:0] rem_reg;
    logic [1:0]    cnt_reg;
    logic          done_reg;
    logic [63:0]   prod;
    logic [31:0]   diff_red;
    logic [31:0]   masked;

    // quotient estimate and final correction
    always_comb
    begin
        prod     = {32'd0, val_reg} * {32'd0, RECIP};
        diff_red = (diff_reg >= MODV) ? diff_reg - MODV : diff_reg;
        masked   = value & (MODV - 32'd1);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= POW2 ? 2'd0 : 2'd3;
            done_reg <= POW2;
        end
        else if (cnt_reg != 2'd0)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            if (cnt_reg == 2'd1)
                done_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            rem_reg <= POW2 ? RW'(masked) : '0;
        end
        else if (cnt_reg == 2'd3)
            quo_reg <= prod[63:32];
        else if (cnt_reg == 2'd2)
            diff_reg <= val_reg - quo_reg * MODV;
        else if (cnt_reg == 2'd1)
            rem_reg <= RW'(diff_red);
    end

    assign done = done_reg;
    assign rem  = rem_reg[IW-1:0];

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (RW'(rem_reg) < RW'(MOD)) || (MOD == 1))
        else $error("remainder out of range");
    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !POW2 |=> !done)
        else $error("done raised too early");
    a_steps_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> !done)
        else $error("done while steps remain");

endmodule

/* rtl/core/branch_predictor_commit_check_top.sv */
// ----------------------------------------------------------------------------
// branch_predictor_commit_check_top
// Commit-time branch predictor check: gshare counters, tagged BTB and a
// return address stack, all held in synchronous RAMs.
// ----------------------------------------------------------------------------
// sequence: the result strobe is registered after the evaluate state, which
//   follows the reduce and read states; the reduce wait is set by the index remainder units
// throughput: one item at a time, busy high until the item has been evaluated
// reset: a clearing pass over max(BHT_ENTRIES, BTB_ENTRIES) entries fills the
//   counters and BTB before busy drops; results cannot be stalled
module branch_predictor_commit_check_top #(
    parameter int BTB_ENTRIES  = 64,
    parameter int BHT_ENTRIES  = 256,
    parameter int RAS_ENTRIES  = 16,
    parameter int COUNTER_BITS = 2,
    parameter int COUNTER_INIT = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic [31:0] commit_pc,
    input  logic [31:0] instruction,
    input  logic [31:0] sequential_next,
    input  logic [31:0] actual_next,
    output logic        result_valid,
    output logic        is_control,
    output logic        is_conditional,
    output logic        pred_taken,
    output logic        direction_correct,
    output logic        target_checked,
    output logic        target_from_stack,
    output logic        stack_empty_on_peek,
    output logic        btb_hit,
    output logic        target_correct,
    output logic [31:0] pred_target,
    output logic        stack_overflow,
    output logic        stack_underflow
);
    import bpcc_pkg::*;

    localparam int BHT_AW = (BHT_ENTRIES > 1) ? $clog2(BHT_ENTRIES) : 1;
    localparam int BTB_AW = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
    localparam int RAS_AW = (RAS_ENTRIES > 1) ? $clog2(RAS_ENTRIES) : 1;
    localparam int RAS_CW = $clog2(RAS_ENTRIES + 1);
    localparam int SW     = RAS_CW + 1;
    localparam int CLR_N  = (BHT_ENTRIES > BTB_ENTRIES) ? BHT_ENTRIES : BTB_ENTRIES;
    localparam int CW     = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int CB     = COUNTER_BITS;
    localparam int CTR_MAX_I  = (1 << COUNTER_BITS) - 1;
    localparam int CTR_INIT_I = (COUNTER_INIT > CTR_MAX_I) ? CTR_MAX_I : COUNTER_INIT;
    localparam logic [CB-1:0] CTR_MAX  = CB'(CTR_MAX_I);
    localparam logic [CB-1:0] CTR_INIT = CB'(CTR_INIT_I);
    localparam logic [CB-1:0] CTR_HALF = CB'(1 << (COUNTER_BITS - 1));
    localparam int BTB_W  = 1 + 2 * ADDR_W;

    bpcc_state_t state_reg, state_next;

    logic [HB_W-1:0]   hbits_reg;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [RAS_AW-1:0] base_reg, base_next;
    logic [RAS_CW-1:0] count_reg, count_next;
    logic [CW-1:0]     clr_reg;
    logic [31:0]       pc_reg, snpc_reg, dnpc_reg;
    bpcc_dec_t         dec_reg;

    logic              accept;
    logic [HB_W-1:0]   hb;
    logic [HIST_W-1:0] hmask;
    logic [31:0]       bht_val;
    logic              bi_done, ti_done;
    logic [BHT_AW-1:0] bi;
    logic [BTB_AW-1:0] ti;

    // ram ports
    logic              bht_we;
    logic [BHT_AW-1:0] bht_waddr;
    logic [CB-1:0]     bht_wdata, bht_rdata;
    logic              btb_we;
    logic [BTB_AW-1:0] btb_waddr;
    logic [BTB_W-1:0]  btb_wdata, btb_rdata;
    logic              ras_we;
    logic [RAS_AW-1:0] ras_waddr, ras_raddr;
    logic [31:0]       ras_rdata;
    logic              rd_en;

    // evaluation signals
    logic [SW-1:0]     top_sum, push_sum;
    logic [RAS_CW-1:0] n_after_pop;
    logic              taken, ptaken, tvalid, from_stack, empty_peek, hit;
    logic              overflow, underflow;
    logic [31:0]       atarget, ptarget;
    logic [CB-1:0]     ctr_upd;
    logic              btb_valid;
    logic [31:0]       btb_tag, btb_tgt;

    // result registers
    logic        rv_reg, ctl_reg, cond_reg, pt_reg, dc_reg, tc_reg, tfs_reg;
    logic        emp_reg, hit_reg, tcor_reg, ovf_reg, unf_reg;
    logic [31:0] ptg_reg;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign rd_en     = (state_reg == ST_READ);

    // history mask from the configured length, capped at sixteen
    always_comb
    begin
        hb      = (hbits_reg > HB_W'(HIST_W)) ? HB_W'(HIST_W) : hbits_reg;
        hmask   = HIST_W'((17'd1 << hb) - 17'd1);
        bht_val = {1'b0, commit_pc[31:1]} ^ {16'd0, hist_reg & hmask};
    end

    // table index remainders
    bpcc_mod #(.MOD(BHT_ENTRIES)) u_bht_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (bht_val),
        .done  (bi_done),
        .rem   (bi)
    );

    bpcc_mod #(.MOD(BTB_ENTRIES)) u_btb_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value ({1'b0, commit_pc[31:1]}),
        .done  (ti_done),
        .rem   (ti)
    );

    // return stack pointers: circular buffer of count entries above base
    always_comb
    begin
        top_sum     = SW'(base_reg) + SW'(count_reg) - SW'(1);
        if (top_sum >= SW'(RAS_ENTRIES))
            top_sum = top_sum - SW'(RAS_ENTRIES);
        ras_raddr   = RAS_AW'(top_sum);
        n_after_pop = (dec_reg.pop && count_reg != '0) ? count_reg - RAS_CW'(1) : count_reg;
        push_sum    = SW'(base_reg) + SW'(n_after_pop);
        if (push_sum >= SW'(RAS_ENTRIES))
            push_sum = push_sum - SW'(RAS_ENTRIES);
    end

    // prediction and update from the read beat
    always_comb
    begin
        {btb_valid, btb_tag, btb_tgt} = btb_rdata;
        taken      = (dnpc_reg != snpc_reg);
        atarget    = taken ? dnpc_reg : snpc_reg;
        ptaken     = dec_reg.cond ? (bht_rdata >= CTR_HALF) : 1'b1;
        tvalid     = 1'b0;
        from_stack = 1'b0;
        empty_peek = 1'b0;
        hit        = 1'b0;
        ptarget    = '0;
        if (ptaken)
        begin
            if (dec_reg.pop)
            begin
                if (count_reg == '0)
                    empty_peek = 1'b1;
                else
                begin
                    ptarget    = ras_rdata;
                    tvalid     = 1'b1;
                    from_stack = 1'b1;
                end
            end
            if (!tvalid && btb_valid && btb_tag == pc_reg)
            begin
                ptarget = btb_tgt;
                tvalid  = 1'b1;
                hit     = 1'b1;
            end
        end
        if (taken)
            ctr_upd = (bht_rdata != CTR_MAX) ? bht_rdata + CB'(1) : bht_rdata;
        else
            ctr_upd = (bht_rdata != '0) ? bht_rdata - CB'(1) : bht_rdata;
        underflow = dec_reg.pop && (count_reg == '0);
        overflow  = dec_reg.push && (n_after_pop == RAS_CW'(RAS_ENTRIES));
    end

    // write ports: clearing pass or the update of one item
    always_comb
    begin
        bht_we     = 1'b0;
        bht_waddr  = bi;
        bht_wdata  = ctr_upd;
        btb_we     = 1'b0;
        btb_waddr  = ti;
        btb_wdata  = {1'b1, pc_reg, atarget};
        ras_we     = 1'b0;
        ras_waddr  = RAS_AW'(push_sum);
        hist_next  = hist_reg;
        base_next  = base_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                bht_we    = ({1'b0, clr_reg} < (CW+1)'(BHT_ENTRIES));
                bht_waddr = BHT_AW'(clr_reg);
                bht_wdata = CTR_INIT;
                btb_we    = ({1'b0, clr_reg} < (CW+1)'(BTB_ENTRIES));
                btb_waddr = BTB_AW'(clr_reg);
                btb_wdata = '0;
            end
            ST_EVAL:
            begin
                if (dec_reg.ctrl)
                begin
                    bht_we = dec_reg.cond;
                    btb_we = taken;
                    ras_we = dec_reg.push;
                    if (dec_reg.cond)
                        hist_next = ((hist_reg << 1) | HIST_W'(taken)) & hmask;
                    if (dec_reg.push)
                    begin
                        if (overflow)
                        begin
                            count_next = RAS_CW'(RAS_ENTRIES);
                            base_next  = (base_reg == RAS_AW'(RAS_ENTRIES - 1)) ? '0
                                         : base_reg + RAS_AW'(1);
                        end
                        else
                            count_next = n_after_pop + RAS_CW'(1);
                    end
                    else
                        count_next = n_after_pop;
                end
            end
            ST_IDLE, ST_REDUCE, ST_READ:
            begin
            end
            default:
            begin
            end
        endcase
    end

    bpcc_ram #(.WIDTH(CB), .DEPTH(BHT_ENTRIES)) u_bht_ram (
        .clk   (clk),
        .we    (bht_we),
        .waddr (bht_waddr),
        .wdata (bht_wdata),
        .re    (rd_en),
        .raddr (bi),
        .rdata (bht_rdata)
    );

    bpcc_ram #(.WIDTH(BTB_W), .DEPTH(BTB_ENTRIES)) u_btb_ram (
        .clk   (clk),
        .we    (btb_we),
        .waddr (btb_waddr),
        .wdata (btb_wdata),
        .re    (rd_en),
        .raddr (ti),
        .rdata (btb_rdata)
    );

    bpcc_ram #(.WIDTH(ADDR_W), .DEPTH(RAS_ENTRIES)) u_ras_ram (
        .clk   (clk),
        .we    (ras_we),
        .waddr (ras_waddr),
        .wdata (snpc_reg),
        .re    (rd_en),
        .raddr (ras_raddr),
        .rdata (ras_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == CW'(CLR_N - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_REDUCE;
            ST_REDUCE: if (bi_done && ti_done) state_next = ST_READ;
            ST_READ:   state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            hbits_reg <= HB_W'(8);
            hist_reg  <= '0;
            base_reg  <= '0;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + CW'(1);
            if (cfg_valid && cfg_ready)
                hbits_reg <= cfg_data;
            hist_reg  <= hist_next;
            base_reg  <= base_next;
            count_reg <= count_next;
            rv_reg    <= (state_reg == ST_EVAL);
        end
    end

    // input beat and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pc_reg   <= commit_pc;
            snpc_reg <= sequential_next;
            dnpc_reg <= actual_next;
            dec_reg  <= bpcc_decode(instruction);
        end
        if (state_reg == ST_EVAL)
        begin
            ctl_reg  <= dec_reg.ctrl;
            cond_reg <= dec_reg.ctrl && dec_reg.cond;
            pt_reg   <= dec_reg.ctrl && ptaken;
            dc_reg   <= dec_reg.ctrl && dec_reg.cond && (ptaken == taken);
            tc_reg   <= dec_reg.ctrl && ptaken;
            tfs_reg  <= dec_reg.ctrl && from_stack;
            emp_reg  <= dec_reg.ctrl && empty_peek;
            hit_reg  <= dec_reg.ctrl && hit;
            tcor_reg <= dec_reg.ctrl && tvalid && (ptarget == atarget);
            ptg_reg  <= dec_reg.ctrl ? ptarget : '0;
            ovf_reg  <= dec_reg.ctrl && overflow;
            unf_reg  <= dec_reg.ctrl && underflow;
        end
    end

    assign result_valid        = rv_reg;
    assign is_control          = ctl_reg;
    assign is_conditional      = cond_reg;
    assign pred_taken          = pt_reg;
    assign direction_correct   = dc_reg;
    assign target_checked      = tc_reg;
    assign target_from_stack   = tfs_reg;
    assign stack_empty_on_peek = emp_reg;
    assign btb_hit             = hit_reg;
    assign target_correct      = tcor_reg;
    assign pred_target         = ptg_reg;
    assign stack_overflow      = ovf_reg;
    assign stack_underflow     = unf_reg;

    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RAS_CW'(RAS_ENTRIES))
        else $error("stack count above depth");
    a_noctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_control |-> pred_target == '0 && !btb_hit && !pred_taken)
        else $error("non-control item with prediction fields set");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");
    a_flow_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(stack_overflow && stack_underflow))
        else $error("overflow and underflow together");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the commit-time branch predictor check block: committed instructions
// are fed through the start/busy port, every result strobe is compared field
// by field with a predictor of the gshare counters, tagged BTB and return
// stack kept inside this bench, across several history lengths.
// ----------------------------------------------------------------------------
module testbench;

    import bpcc_pkg::*;

    localparam int N_BTB  = 64;
    localparam int N_BHT  = 256;
    localparam int N_RAS  = 16;
    localparam int SETTLE = 8;
    localparam logic [6:0] OP_IMM = 7'h13;

    typedef enum logic [1:0] {
        JOB_INSN,
        JOB_CFG,
        JOB_PAUSE
    } job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [31:0] pc;
        logic [31:0] word;
        logic [31:0] seq_pc;
        logic [31:0] next_pc;
        logic [4:0]  hist_len;
        int          gap;
    } job_t;

    typedef struct {
        logic        ctl;
        logic        cnd;
        logic        ptaken;
        logic        dir_ok;
        logic        tchk;
        logic        from_ras;
        logic        ras_empty;
        logic        hit;
        logic        tgt_ok;
        logic [31:0] ptarget;
        logic        ovf;
        logic        unf;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic [31:0] commit_pc = '0;
    logic [31:0] instruction = '0;
    logic [31:0] sequential_next = '0;
    logic [31:0] actual_next = '0;
    logic        busy;
    logic        cfg_ready;
    logic        result_valid;
    logic        is_control;
    logic        is_conditional;
    logic        pred_taken;
    logic        direction_correct;
    logic        target_checked;
    logic        target_from_stack;
    logic        stack_empty_on_peek;
    logic        btb_hit;
    logic        target_correct;
    logic [31:0] pred_target;
    logic        stack_overflow;
    logic        stack_underflow;

    job_t     pending[$];
    outcome_t outcome_q[$];
    int       errors = 0;
    int       quiet = 0;
    int       n_results = 0;
    int       n_ctrl = 0;
    int       n_hits = 0;
    int       n_ras = 0;
    int       n_ovf = 0;
    int       n_unf = 0;
    int       n_cfg = 0;

    // predictor state
    logic        btb_v[N_BTB];
    logic [31:0] btb_tag[N_BTB];
    logic [31:0] btb_tgt[N_BTB];
    logic [1:0]  ctr[N_BHT];
    logic [15:0] ghist;
    logic [31:0] ras[N_RAS];
    int          ras_cnt;
    logic [4:0]  hist_len_cfg;

    branch_predictor_commit_check_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .commit_pc           (commit_pc),
        .instruction         (instruction),
        .sequential_next     (sequential_next),
        .actual_next         (actual_next),
        .result_valid        (result_valid),
        .is_control          (is_control),
        .is_conditional      (is_conditional),
        .pred_taken          (pred_taken),
        .direction_correct   (direction_correct),
        .target_checked      (target_checked),
        .target_from_stack   (target_from_stack),
        .stack_empty_on_peek (stack_empty_on_peek),
        .btb_hit             (btb_hit),
        .target_correct      (target_correct),
        .pred_target         (pred_target),
        .stack_overflow      (stack_overflow),
        .stack_underflow     (stack_underflow)
    );

    // clock
    always #10 clk = ~clk;

    function automatic logic is_lr(input logic [4:0] r);
        return (r == REG_RA) || (r == REG_T0);
    endfunction

    // indirect jump stack action: {pop, push}
    function automatic logic [1:0] ind_action(input logic [4:0] rd, input logic [4:0] rs1);
        if (!is_lr(rd) && !is_lr(rs1))
            return 2'b00;
        if (!is_lr(rd))
            return 2'b10;
        if (!is_lr(rs1) || rd == rs1)
            return 2'b01;
        return 2'b11;
    endfunction

    function automatic logic [15:0] hist_mask();
        int hb;
        hb = (hist_len_cfg > 16) ? 16 : int'(hist_len_cfg);
        return (hb == 0) ? 16'h0 : 16'((32'd1 << hb) - 1);
    endfunction

    // expected outcome of one committed instruction, then training
    function automatic void predict_commit(input logic [31:0] pc, input logic [31:0] w,
                                           input logic [31:0] sn, input logic [31:0] dn);
        outcome_t o;
        logic ctl, cnd, psh, pp, taken, tvalid;
        logic [1:0] act;
        logic [31:0] atgt;
        logic [15:0] hm;
        int bi, ti;
        o = '{default: '0};
        ctl = 0; cnd = 0; psh = 0; pp = 0;
        if (w[1:0] != QUAD_FULL)
        begin
            if (w[1:0] == QUAD_C1)
            begin
                if (w[15:13] == C_F3_JAL)
                begin
                    ctl = 1; psh = 1;
                end
                else if (w[15:13] == C_F3_J)
                    ctl = 1;
                else if (w[15:13] == C_F3_BEQZ || w[15:13] == C_F3_BNEZ)
                begin
                    ctl = 1; cnd = 1;
                end
            end
            else if (w[1:0] == QUAD_C2 && w[15:13] == C_F3_JR && w[6:2] == REG_ZERO
                     && w[11:7] != REG_ZERO)
            begin
                ctl = 1;
                if (!w[12])
                    pp = is_lr(w[11:7]);
                else
                begin
                    act = ind_action(REG_RA, w[11:7]);
                    pp = act[1]; psh = act[0];
                end
            end
        end
        else if (w[6:0] == OP_BRANCH)
        begin
            if (w[14:12] != F3_RSV0 && w[14:12] != F3_RSV1)
            begin
                ctl = 1; cnd = 1;
            end
        end
        else if (w[6:0] == OP_JAL)
        begin
            ctl = 1; psh = is_lr(w[11:7]);
        end
        else if (w[6:0] == OP_JALR && w[14:12] == F3_JALR)
        begin
            ctl = 1;
            act = ind_action(w[11:7], w[19:15]);
            pp = act[1]; psh = act[0];
        end

        if (ctl)
        begin
            taken = (dn != sn);
            atgt = taken ? dn : sn;
            hm = hist_mask();
            bi = int'((pc[8:1] ^ (ghist[7:0] & hm[7:0])));
            ti = int'(pc[6:1]);
            o.ctl = 1;
            o.cnd = cnd;
            o.ptaken = cnd ? (ctr[bi] >= 2'd2) : 1'b1;
            tvalid = 0;
            // target lookup: stack top for returns, else BTB
            if (o.ptaken)
            begin
                if (pp)
                begin
                    if (ras_cnt == 0)
                        o.ras_empty = 1;
                    else
                    begin
                        o.ptarget = ras[ras_cnt - 1];
                        tvalid = 1;
                        o.from_ras = 1;
                    end
                end
                if (!tvalid && btb_v[ti] && btb_tag[ti] == pc)
                begin
                    o.ptarget = btb_tgt[ti];
                    tvalid = 1;
                    o.hit = 1;
                end
            end
            o.dir_ok = cnd && (o.ptaken == taken);
            o.tchk = o.ptaken;
            o.tgt_ok = tvalid && (o.ptarget == atgt);
            // training
            if (cnd)
            begin
                if (taken && ctr[bi] != 2'd3)
                    ctr[bi] = ctr[bi] + 2'd1;
                else if (!taken && ctr[bi] != 2'd0)
                    ctr[bi] = ctr[bi] - 2'd1;
                ghist = {ghist[14:0], taken} & hm;
            end
            if (taken)
            begin
                btb_v[ti] = 1;
                btb_tag[ti] = pc;
                btb_tgt[ti] = atgt;
            end
            if (pp)
            begin
                if (ras_cnt == 0)
                    o.unf = 1;
                else
                    ras_cnt--;
            end
            if (psh)
            begin
                if (ras_cnt >= N_RAS)
                begin
                    for (int i = 0; i < N_RAS - 1; i++)
                        ras[i] = ras[i + 1];
                    ras[N_RAS - 1] = sn;
                    o.ovf = 1;
                end
                else
                begin
                    ras[ras_cnt] = sn;
                    ras_cnt++;
                end
            end
        end
        outcome_q.push_back(o);
    endfunction

    // driver: one beat per start/busy handshake, config beats only when idle
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_start, nxt_cfg, free;
        job_t j;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_start = start;
            nxt_cfg = cfg_valid;
            free = 0;
            if (start && !busy)
            begin
                predict_commit(commit_pc, instruction, sequential_next, actual_next);
                free = 1;
            end
            else if (cfg_valid && cfg_ready)
            begin
                hist_len_cfg = cfg_data;
                n_cfg++;
                free = 1;
            end
            else if (!start && !cfg_valid)
                free = 1;

            if (outcome_q.size() == 0 && !start && !busy && !result_valid)
                quiet++;
            else
                quiet = 0;

            if (free)
            begin
                nxt_start = 0;
                nxt_cfg = 0;
                if (pending.size() != 0)
                begin
                    if (pending[0].gap > 0)
                        pending[0].gap--;
                    else if (pending[0].kind == JOB_INSN
                             || (outcome_q.size() == 0 && quiet >= SETTLE))
                    begin
                        j = pending.pop_front();
                        if (j.kind == JOB_INSN)
                        begin
                            nxt_start = 1;
                            commit_pc <= j.pc;
                            instruction <= j.word;
                            sequential_next <= j.seq_pc;
                            actual_next <= j.next_pc;
                        end
                        else if (j.kind == JOB_CFG)
                        begin
                            nxt_cfg = 1;
                            cfg_data <= j.hist_len;
                        end
                    end
                end
            end
            start <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
        end
    endtask

    // monitor: every strobe is one result beat
    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n && result_valid)
        begin
            if (outcome_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual target %h",
                         $time, pred_target);
            end
            else
            begin
                o = outcome_q.pop_front();
                n_results++;
                n_ctrl += int'(o.ctl);
                n_hits += int'(o.hit);
                n_ras += int'(o.from_ras);
                n_ovf += int'(o.ovf);
                n_unf += int'(o.unf);
                check_field("is_control", 32'(o.ctl), 32'(is_control));
                check_field("is_conditional", 32'(o.cnd), 32'(is_conditional));
                check_field("pred_taken", 32'(o.ptaken), 32'(pred_taken));
                check_field("direction_correct", 32'(o.dir_ok), 32'(direction_correct));
                check_field("target_checked", 32'(o.tchk), 32'(target_checked));
                check_field("target_from_stack", 32'(o.from_ras), 32'(target_from_stack));
                check_field("stack_empty_on_peek", 32'(o.ras_empty),
                            32'(stack_empty_on_peek));
                check_field("btb_hit", 32'(o.hit), 32'(btb_hit));
                check_field("target_correct", 32'(o.tgt_ok), 32'(target_correct));
                check_field("pred_target", o.ptarget, pred_target);
                check_field("stack_overflow", 32'(o.ovf), 32'(stack_overflow));
                check_field("stack_underflow", 32'(o.unf), 32'(stack_underflow));
            end
        end
    end

    // queue helpers
    int burst_left = 0;
    logic burst_mode = 0;

    function automatic int draw_gap();
        if (burst_left == 0)
        begin
            burst_mode = !burst_mode;
            burst_left = $urandom_range(20, 80);
        end
        burst_left--;
        return burst_mode ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic void add_insn(input logic [31:0] pc, input logic [31:0] w,
                                     input logic [31:0] sn, input logic [31:0] dn);
        job_t j;
        j = '{JOB_INSN, pc, w, sn, dn, 5'd0, draw_gap()};
        pending.push_back(j);
    endfunction

    function automatic void add_cfg(input logic [4:0] v);
        job_t j;
        j = '{JOB_CFG, 32'd0, 32'd0, 32'd0, 32'd0, v, draw_gap()};
        pending.push_back(j);
    endfunction

    // instruction words by class
    function automatic logic [31:0] make_word(input int kind);
        logic [31:0] w;
        logic [2:0] bf3[6] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
        w = $urandom;
        case (kind)
            0: begin w[6:0] = OP_BRANCH; w[14:12] = bf3[$urandom_range(0, 5)]; end
            1: begin w[6:0] = OP_JAL; w[11:7] = $urandom_range(0, 1) ? REG_RA : REG_T0; end
            2: begin w[6:0] = OP_JAL; w[11:7] = REG_ZERO; end
            3: begin
                w[6:0] = OP_JALR; w[14:12] = F3_JALR; w[11:7] = REG_ZERO;
                w[19:15] = $urandom_range(0, 1) ? REG_RA : REG_T0;
            end
            4: begin
                w[6:0] = OP_JALR; w[14:12] = F3_JALR;
                w[11:7] = 5'($urandom_range(6, 31)); w[19:15] = 5'($urandom_range(6, 31));
            end
            5: begin w[1:0] = QUAD_C1; w[15:13] = $urandom_range(0, 1) ? C_F3_BEQZ : C_F3_BNEZ; end
            6: begin w[1:0] = QUAD_C1; w[15:13] = $urandom_range(0, 1) ? C_F3_JAL : C_F3_J; end
            7: begin
                w[1:0] = QUAD_C2; w[15:13] = C_F3_JR; w[12] = 1'b0;
                w[11:7] = REG_RA; w[6:2] = REG_ZERO;
            end
            8: begin
                w[1:0] = QUAD_C2; w[15:13] = C_F3_JR; w[12] = 1'b1;
                w[11:7] = $urandom_range(0, 1) ? REG_T0 : 5'd7; w[6:2] = REG_ZERO;
            end
            default: w[6:0] = OP_IMM;
        endcase
        return w;
    endfunction

    // stimulus
    logic [31:0] site_pc[32];
    logic [31:0] site_w[32];
    logic [31:0] site_tgt[32];
    int          site_kind[32];
    int          site_bias[32];
    logic [31:0] call_stack[$];
    logic [4:0]  phase_hist[6] = '{5'd8, 5'd0, 5'd16, 5'd31, 5'd1, 5'd5};

    initial
    begin
        int k;
        logic [31:0] pc, w, sn, dn;
        // directed: every class, link register cases, address extremes
        add_insn(32'h0000_1000, 32'h0000_0013, 32'h0000_1004, 32'h0000_1004);
        add_insn(32'h0000_1004, 32'h0000_8067, 32'h0000_1008, 32'h0000_2000); // ret on empty
        add_insn(32'h0000_1008, 32'h0080_00ef, 32'h0000_100c, 32'h0000_1010); // call x1
        add_insn(32'h0000_1010, 32'h0000_8067, 32'h0000_1014, 32'h0000_100c); // ret from stack
        add_insn(32'h0000_1014, 32'h0002_80e7, 32'h0000_1018, 32'h0000_3000); // pop and push
        add_insn(32'h0000_1018, 32'h0000_80e7, 32'h0000_101c, 32'h0000_3000); // rd == rs1 push
        add_insn(32'h0000_101c, 32'h0000_9067, 32'h0000_1020, 32'h0000_1020); // jalr bad funct3
        add_insn(32'h0000_1020, 32'h0000_0063, 32'h0000_1024, 32'h0000_1024); // beq not taken
        add_insn(32'h0000_1024, 32'h0000_1063, 32'h0000_1028, 32'h0000_4000); // bne taken
        add_insn(32'h0000_1028, 32'h0000_2063, 32'h0000_102c, 32'h0000_102c); // reserved branch
        add_insn(32'h0000_102c, 32'h0000_3063, 32'h0000_1030, 32'h0000_5000); // reserved branch
        add_insn(32'h0000_1030, 32'h0000_006f, 32'h0000_1034, 32'h0000_1100); // plain jal
        add_insn(32'h0000_1034, 32'h0000_2001, 32'h0000_1036, 32'h0000_1200); // c.jal
        add_insn(32'h0000_1036, 32'h0000_a001, 32'h0000_1038, 32'h0000_1300); // c.j
        add_insn(32'h0000_1038, 32'h0000_c001, 32'h0000_103a, 32'h0000_103a); // c.beqz
        add_insn(32'h0000_103a, 32'h0000_e001, 32'h0000_103c, 32'h0000_1400); // c.bnez
        add_insn(32'h0000_103c, 32'h0000_8082, 32'h0000_103e, 32'h0000_1036); // c.jr ra
        add_insn(32'h0000_103e, 32'h0000_8002, 32'h0000_1040, 32'h0000_1040); // c.jr x0
        add_insn(32'h0000_1040, 32'h0000_9282, 32'h0000_1042, 32'h0000_6000); // c.jalr t0
        add_insn(32'h0000_1042, 32'h0000_9082, 32'h0000_1044, 32'h0000_6000); // c.jalr ra
        add_insn(32'h0000_1044, 32'h0000_80a2, 32'h0000_1046, 32'h0000_1046); // c.jr rs2 != 0
        add_insn(32'h0000_0000, 32'hffff_ffe3, 32'h0000_0004, 32'hffff_fffe);
        add_insn(32'hffff_fffe, 32'hffff_ffe3, 32'hffff_ffff, 32'h0000_0000);
        add_insn(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_insn(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        // program sites revisited so the tables train and hit
        for (int i = 0; i < 32; i++)
        begin
            site_kind[i] = i % 10;
            site_pc[i] = (i == 0) ? 32'h0 : (i == 31) ? 32'hffff_fffe : ($urandom & ~32'h1);
            site_w[i] = make_word(site_kind[i]);
            site_tgt[i] = $urandom & ~32'h1;
            site_bias[i] = $urandom_range(0, 100);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph != 0)
                add_cfg(phase_hist[ph]);
            if (ph == 3)
                pending.push_back('{JOB_PAUSE, 32'd0, 32'd0, 32'd0, 32'd0, 5'd0, 0});
            for (int n = 0; n < 222; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    // noise: any field value at all
                    pc = $urandom;
                    w = $urandom;
                    sn = $urandom;
                    dn = $urandom_range(0, 1) ? sn : $urandom;
                end
                else
                begin
                    k = $urandom_range(0, 31);
                    pc = site_pc[k];
                    w = site_w[k];
                    sn = pc + ((w[1:0] == QUAD_FULL) ? 32'd4 : 32'd2);
                    case (site_kind[k])
                        0, 5: dn = ($urandom_range(0, 99) < site_bias[k]) ? site_tgt[k] : sn;
                        1, 6, 8:
                        begin
                            dn = site_tgt[k];
                            if (site_kind[k] != 6 || w[15:13] == C_F3_JAL)
                                call_stack.push_back(sn);
                            if (call_stack.size() > 40)
                                void'(call_stack.pop_front());
                        end
                        3, 7: dn = (call_stack.size() != 0) ? call_stack.pop_back()
                                                           : ($urandom & ~32'h1);
                        4: dn = ($urandom_range(0, 3) == 0) ? ($urandom & ~32'h1) : site_tgt[k];
                        2: dn = site_tgt[k];
                        default: dn = sn;
                    endcase
                end
                add_insn(pc, w, sn, dn);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (!(pending.size() == 0 && !start && !cfg_valid && outcome_q.size() == 0))
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d results checked: %0d control transfers, %0d btb hits, %0d stack targets",
                 n_results, n_ctrl, n_hits, n_ras);
        $display("stack overflows %0d, underflows %0d, history settings written %0d",
                 n_ovf, n_unf, n_cfg);
        if (errors == 0 && outcome_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // predictor reset state, matching the block after its clearing pass
    initial
    begin
        for (int i = 0; i < N_BTB; i++)
        begin
            btb_v[i] = 0; btb_tag[i] = '0; btb_tgt[i] = '0;
        end
        for (int i = 0; i < N_BHT; i++)
            ctr[i] = 2'd1;
        for (int i = 0; i < N_RAS; i++)
            ras[i] = '0;
        ghist = '0;
        ras_cnt = 0;
        hist_len_cfg = 5'd8;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
